// ===== hdl/ordered_list_insert_delete_macros.svh =====
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OLID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/olid_pkg.sv =====
// types and codes shared by the ordered list block
`default_nettype none

package olid_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } olid_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] head_value;
  } olid_rsp_t;

  // search wave handed from cell to cell
  typedef struct packed {
    logic tok;
    logic seen;
  } olid_link_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } olid_state_t;

endpackage

`default_nettype wire

// ===== hdl/olid_cell.sv =====
// one list slot: holds an entry, compares it and shifts up on delete
`default_nettype none

module olid_cell
  import olid_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire olid_link_t         link_in,
  output olid_link_t              link_out,
  input  wire logic               flush,
  input  wire logic signed [31:0] key,
  input  wire logic               wr_en,
  input  wire logic signed [31:0] wdata,
  input  wire logic signed [31:0] right_data,
  output logic signed [31:0]      data,
  output logic                    hit
);

  logic tok;
  logic seen;

  // wave is here and a match was seen here or upstream
  assign hit      = tok && (seen || (data == key));
  assign link_out = '{tok: tok, seen: hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      seen <= 1'b0;
    end else begin
      tok  <= link_in.tok && !flush;
      seen <= link_in.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data <= wdata;
    end else if (hit) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ordered_list_insert_delete.sv =====
// top level of the ordered list: control, fill count and the row of cells
//
//   channel   dir  handshake            beat
//   request   in   start & !busy        req  (op, value)
//   result    out  done, one cycle      rsp  (status, entry_count, head_value)
//
// append, or delete on an empty list: from accept straight to the report state, which raises done
// delete: scan state, then report state; a search wave moves one cell per cycle down the row
//   of cells, and every cell at or past the first match takes its right
//   neighbor's entry as the wave passes, so the gap closes in the same sweep
// synchronous reset clears the fill count and control; the entries are not
//   cleared, only the first fill of them are ever read
// the receiver cannot stall: done is high for one cycle and busy then drops
`default_nettype none

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire olid_req_t req,
  output logic           done,
  output olid_rsp_t      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  olid_state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [IW-1:0] pos, pos_next;
  logic signed [31:0] key, key_next;
  logic [1:0] status, status_next;

  logic launch;
  logic flush;
  logic full;
  logic found;
  logic [31:0] count_wide;

  olid_link_t         link  [CAPACITY+1];
  logic signed [31:0] cdata [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] wr_en;

  assign full  = (fill == CW'(CAPACITY));
  // only the cell under the wave can hit, and its hit carries the upstream ones
  assign found = |hits;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      pos    <= '0;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      pos    <= pos_next;
      status <= status_next;
    end
  end

  // search key needs no reset
  always_ff @(posedge clk) begin
    key <= key_next;
  end

  // next state, counters and cell controls
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    pos_next    = pos;
    key_next    = key;
    status_next = status;
    launch      = 1'b0;
    flush       = 1'b0;
    wr_en       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          key_next = req.value;
          pos_next = '0;
          if (req.op == OP_APPEND) begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              // new entry lands in the first free cell
              for (int i = 0; i < CAPACITY; i++) begin
                wr_en[i] = (fill == CW'(i));
              end
              fill_next   = fill + CW'(1);
              status_next = ST_OK;
            end
            state_next = S_REPORT;
          end else if (fill == '0) begin
            status_next = ST_EMPTY;
            state_next  = S_REPORT;
          end else begin
            launch     = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pos_next = pos + IW'(1);
        // wave sits on the last held entry: stop it and settle the outcome
        if (CW'(pos) == fill - CW'(1)) begin
          flush = 1'b1;
          if (found) begin
            fill_next   = fill - CW'(1);
            status_next = ST_OK;
          end else begin
            status_next = ST_NOT_FOUND;
          end
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // head of the wave enters cell 0 with nothing seen yet
  assign link[0] = '{tok: launch, seen: 1'b0};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] right;
    if (g == CAPACITY - 1) begin : g_last
      // beyond the tail: whatever shifts in here is never read
      assign right = cdata[g];
    end else begin : g_mid
      assign right = cdata[g+1];
    end
    olid_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .link_in    (link[g]),
      .link_out   (link[g+1]),
      .flush      (flush),
      .key        (key),
      .wr_en      (wr_en[g]),
      .wdata      (req.value),
      .right_data (right),
      .data       (cdata[g]),
      .hit        (hits[g])
    );
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPORT);

  // count field is the fill masked to five bits
  assign count_wide       = 32'(fill);
  assign rsp.status       = status;
  assign rsp.entry_count  = count_wide[4:0];
  assign rsp.head_value   = (fill == '0) ? 32'sd0 : cdata[0];

endmodule

`default_nettype wire

// ===== hdl/olid_check.sv =====
// port-level checks for the ordered list, bound to the top level
`default_nettype none
`include "ordered_list_insert_delete_macros.svh"

module olid_check
  import olid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire olid_req_t req,
  input wire logic      done,
  input wire olid_rsp_t rsp
);

  localparam logic [31:0] CAP_WIDE = 32'(CAPACITY);
  localparam logic [4:0]  CAP_COUNT = CAP_WIDE[4:0];

  // an accepted request keeps the block busy until its result
  `OLID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  // a result beat closes the request
  `OLID_ASSERT_NEXT(a_done_idle, done, !busy && !done, "busy or done held after result")
  // a refused append reports a full list
  `OLID_ASSERT_NOW(a_full_count, done && rsp.status == ST_FULL, rsp.entry_count == CAP_COUNT, "full status with wrong count")
  // an empty delete reports nothing held
  `OLID_ASSERT_NOW(a_empty_rsp, done && rsp.status == ST_EMPTY, rsp.entry_count == 5'd0 && rsp.head_value == 32'sd0, "empty status with data")

endmodule

bind ordered_list_insert_delete olid_check #(.CAPACITY(CAPACITY)) u_olid_check (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the ordered list: append and delete requests against a predictor
`timescale 1ns / 1ps

module tb_top;
  import olid_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 1850;
  // longest request is a delete on a full list, which scans every entry, plus slack
  localparam int SETTLE_CYCLES = CAPACITY + 8;

  // one pending request beat, the idle cycles that follow it, and whether
  // the sender must wait for every outstanding result before issuing it
  typedef struct {
    olid_req_t   req;
    int unsigned gap;
    bit          drain;
  } list_req_t;

  logic      clk;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  olid_req_t req   = '0;
  logic      busy;
  logic      done;
  olid_rsp_t rsp;

  ordered_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // requests waiting to be driven, results waiting to arrive
  list_req_t   pending_reqs[$];
  olid_rsp_t   expected_rsps[$];

  // predictor copy of the list contents, head at index 0
  logic [31:0] list_model[$];

  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned gap_left       = 0;
  int unsigned error_count    = 0;
  int unsigned status_seen[4] = '{default: 0};
  int unsigned peak_fill      = 0;

  // stimulus helpers: value pool and recently appended values
  logic [31:0] value_pool[8];
  logic [31:0] recent_vals[$];
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predicts one request and updates the list copy
  function automatic olid_rsp_t predict_list_op(olid_req_t r);
    olid_rsp_t  res;
    int         hit;
    logic [1:0] st;
    hit = -1;
    if (r.op == OP_APPEND) begin
      // a full list refuses the value and stays as it is
      if (list_model.size() >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        list_model.push_back(r.value);
        st = ST_OK;
      end
    end else if (list_model.size() == 0) begin
      st = ST_EMPTY;
    end else begin
      // first match from the head, compared as full 32-bit patterns
      for (int i = 0; i < list_model.size(); i++) begin
        if (hit < 0 && list_model[i] == r.value) hit = i;
      end
      if (hit < 0) begin
        st = ST_NOT_FOUND;
      end else begin
        list_model.delete(hit);
        st = ST_OK;
      end
    end
    res.status      = st;
    res.entry_count = 5'(list_model.size());
    res.head_value  = (list_model.size() > 0) ? list_model[0] : '0;
    return res;
  endfunction

  // idle cycles after a beat: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // pool values, small values and recent appends collide often so deletes hit; the rest spans all 32 bits
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return value_pool[$urandom_range(0, 7)];
    if (r < 55) return 32'($signed($urandom_range(0, 7)) - 4);
    if (r < 75 && recent_vals.size() > 0) return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    return $urandom();
  endfunction

  task automatic add_req(logic op, logic [31:0] v, bit drain);
    list_req_t item;
    item.req.op    = op;
    item.req.value = v;
    item.gap       = pick_gap();
    item.drain     = drain;
    pending_reqs.push_back(item);
    if (op == OP_APPEND) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > CAPACITY) void'(recent_vals.pop_front());
    end
  endtask

  // driver: changes inputs on the falling edge only
  always @(negedge clk) begin : driver
    list_req_t nxt;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && issued_count != accepted_count) begin
      // beat still waiting for busy to drop, hold it
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
      // start stays high across back-to-back beats, assigned once
      nxt          = pending_reqs.pop_front();
      req          <= nxt.req;
      start        <= 1'b1;
      gap_left     <= nxt.gap;
      issued_count <= issued_count + 1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: samples on the rising edge, checks the done beat, then
  // predicts any request beat accepted at the same edge
  always @(posedge clk) begin : monitor
    olid_rsp_t want;
    olid_rsp_t got;
    if (!rst) begin
      if (done) begin
        got = rsp;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          status_seen[got.status] <= status_seen[got.status] + 1;
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            error_count++;
          end
          if (got.head_value !== want.head_value) begin
            $display("%0t: head_value expected %h actual %h",
                     $time, want.head_value, got.head_value);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_rsps.push_back(predict_list_op(req));
        accepted_count <= accepted_count + 1;
        if (list_model.size() > peak_fill) peak_fill <= list_model.size();
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int unsigned n;
    int unsigned burst_len;
    int unsigned append_pct;
    logic        op;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    // directed part
    // delete on an empty list right after reset
    add_req(OP_DELETE, 32'h0000_0005, 1'b0);
    // field extremes
    add_req(OP_APPEND, 32'h8000_0000, 1'b0);
    add_req(OP_APPEND, 32'h7fff_ffff, 1'b0);
    add_req(OP_APPEND, 32'h0000_0000, 1'b0);
    add_req(OP_APPEND, 32'hffff_ffff, 1'b0);
    // one bit off a held value: no match
    add_req(OP_DELETE, 32'h7fff_fffe, 1'b0);
    // remove the tail, then the head
    add_req(OP_DELETE, 32'hffff_ffff, 1'b0);
    add_req(OP_DELETE, 32'h8000_0000, 1'b0);
    // fill up with duplicates of 7 sprinkled in
    for (int i = 0; i < CAPACITY - 2; i++) begin
      add_req(OP_APPEND, (i % 3 == 0) ? 32'h0000_0007 : 32'(i) * 32'h1111_1111, 1'b0);
    end
    // append to a full list is refused
    add_req(OP_APPEND, 32'h0000_0001, 1'b0);
    // delete from the middle, then the first of several duplicates
    add_req(OP_DELETE, 32'h0000_0000, 1'b0);
    add_req(OP_DELETE, 32'h0000_0007, 1'b0);

    // random part: bursts lean toward appends or deletes so the fill
    // sweeps between empty and full; some bursts run without idling
    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst_len  = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: append_pct = 85;
        1: append_pct = 50;
        default: append_pct = 20;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < burst_len && n < RANDOM_ITEMS; k++) begin
        op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_DELETE;
        // the sender waits for all results now and then
        add_req(op, pick_value(), (n % 300 == 0) || ($urandom_range(0, 99) == 0));
        n++;
      end
    end
    no_idle = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() > 0 || issued_count != accepted_count) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests %0d, results ok %0d, empty %0d, not found %0d, full %0d",
             accepted_count, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    $display("list fill reached %0d of %0d entries", peak_fill, CAPACITY);
    if (error_count == 0) begin
      $display("ordered_list_insert_delete test passed");
    end else begin
      $display("ordered_list_insert_delete test failed");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_rsps.size());
    $display("ordered_list_insert_delete test failed");
    $finish;
  end

endmodule
